### design/tlb_lru_translate_unit_assert.svh
// Assertion macros for the checker file of the translation unit.
// Depends on nothing; include with the bare file name.
`ifndef TLB_LRU_TRANSLATE_UNIT_ASSERT_SVH
`define TLB_LRU_TRANSLATE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TLBL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TLBL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/tlbl_pkg.sv
// Shared types and fixed field widths of the translation unit.
// Used by the page table, the buffer cells and the top level; depends on nothing.
package tlbl_pkg;

  localparam int VADDR_W  = 19;
  localparam int TPAGE_W  = 7;
  localparam int FRAME_W  = 7;
  localparam int OFFSET_W = 12;
  localparam int SLOT_OUT_W = 4;
  localparam int TOTAL_W  = 32;

  localparam logic FUNC_TRANSLATE = 1'b0;
  localparam logic FUNC_WRITE     = 1'b1;

  // Running search state handed from one buffer cell to the next.
  typedef struct packed {
    logic hit;
    logic free;
    logic vic;
  } scan_flags_t;

  // Update broadcast to every cell when a translation commits.
  typedef struct packed {
    logic apply;
    logic fill;
  } upd_cmd_t;

  // Page-table port requests.
  typedef struct packed {
    logic wr;
    logic rd;
  } pt_ctrl_t;

endpackage

### design/tlb_lru_translate_unit.sv
// Fully associative translation buffer with least-recently-used replacement
// in front of a page table held in the block.
// Request channel (req_valid/req_stall): func, virt_addr, table_page, table_frame.
// func selects a translation or a page-table write.
// Response channel (rsp_valid/rsp_stall): one item per request, in order.
// A page-table write is answered with is_write_ack set and every other field
// zero; the buffer keeps its entries.
// A translation runs a search token through the row of BUFFER_ENTRIES cells,
// one cell per cycle, then commits its result; a new request is taken only
// once the current translation or write has been answered.
// After reset the page table is filled with the identity map, one entry a
// cycle; req_stall stays high until that sweep ends.
// The result sits in an output register. A request is accepted while a result
// waits, but the next result commits only once the previous one has been taken.
// PAGE_COUNT and PAGE_BYTES must be powers of two.
// Depends on tlbl_pkg, tlbl_page_table and tlbl_cell.
module tlb_lru_translate_unit #(
  parameter int BUFFER_ENTRIES = 10,
  parameter int PAGE_COUNT     = 128,
  parameter int PAGE_BYTES     = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic                            func,
  input  logic [tlbl_pkg::VADDR_W-1:0]    virt_addr,
  input  logic [tlbl_pkg::TPAGE_W-1:0]    table_page,
  input  logic [tlbl_pkg::FRAME_W-1:0]    table_frame,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic                            is_write_ack,
  output logic                            hit,
  output logic [tlbl_pkg::FRAME_W-1:0]    frame_number,
  output logic [tlbl_pkg::OFFSET_W-1:0]   page_offset,
  output logic [tlbl_pkg::SLOT_OUT_W-1:0] slot_used,
  output logic [tlbl_pkg::TOTAL_W-1:0]    hit_total,
  output logic [tlbl_pkg::TOTAL_W-1:0]    miss_total
);
  import tlbl_pkg::*;

  localparam int PAGE_W = $clog2(PAGE_COUNT);
  localparam int OFF_W  = $clog2(PAGE_BYTES);
  localparam int VPN_W  = VADDR_W - OFF_W;
  localparam int SLOT_W = $clog2(BUFFER_ENTRIES);
  localparam int RANK_W = $clog2(BUFFER_ENTRIES + 1);
  localparam int LAST   = BUFFER_ENTRIES - 1;

  localparam logic [2:0] ST_INIT    = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_SCAN    = 3'd2;
  localparam logic [2:0] ST_RESOLVE = 3'd3;
  localparam logic [2:0] ST_ACK     = 3'd4;

  logic [2:0]          state;
  logic [SLOT_W-1:0]   scan_cnt;
  logic [PAGE_W-1:0]   cur_page;
  logic [OFFSET_W-1:0] cur_offset;
  logic [PAGE_W-1:0]   cur_tpage;
  logic [FRAME_W-1:0]  cur_tframe;
  logic [TOTAL_W-1:0]  hits_seen;
  logic [TOTAL_W-1:0]  misses_seen;

  logic                        accept;
  logic                        out_free;
  logic                        commit;
  logic                        ack_done;
  logic [VPN_W+PAGE_W-1:0]     vpn_ext;
  logic [OFF_W+OFFSET_W-1:0]   off_ext;
  logic [TPAGE_W+PAGE_W-1:0]   tpage_ext;
  logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

  pt_ctrl_t            pt_ctrl;
  logic [FRAME_W-1:0]  pt_frame;
  logic                pt_busy;

  upd_cmd_t            upd;
  logic [SLOT_W-1:0]   upd_slot;
  logic [RANK_W-1:0]   upd_old_rank;
  logic [FRAME_W-1:0]  upd_frame;
  logic                scan_en;

  scan_flags_t         cin_flags     [BUFFER_ENTRIES];
  logic [SLOT_W-1:0]   cin_hit_slot  [BUFFER_ENTRIES];
  logic [RANK_W-1:0]   cin_hit_rank  [BUFFER_ENTRIES];
  logic [FRAME_W-1:0]  cin_hit_frame [BUFFER_ENTRIES];
  logic [SLOT_W-1:0]   cin_free_slot [BUFFER_ENTRIES];
  logic [SLOT_W-1:0]   cin_vic_slot  [BUFFER_ENTRIES];
  logic [RANK_W-1:0]   cin_vic_rank  [BUFFER_ENTRIES];
  scan_flags_t         tok_flags     [BUFFER_ENTRIES];
  logic [SLOT_W-1:0]   tok_hit_slot  [BUFFER_ENTRIES];
  logic [RANK_W-1:0]   tok_hit_rank  [BUFFER_ENTRIES];
  logic [FRAME_W-1:0]  tok_hit_frame [BUFFER_ENTRIES];
  logic [SLOT_W-1:0]   tok_free_slot [BUFFER_ENTRIES];
  logic [SLOT_W-1:0]   tok_vic_slot  [BUFFER_ENTRIES];
  logic [RANK_W-1:0]   tok_vic_rank  [BUFFER_ENTRIES];

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign commit    = (state == ST_RESOLVE) && out_free;
  assign ack_done  = (state == ST_ACK) && out_free;
  assign scan_en   = (state == ST_SCAN);

  // Page number and offset; pages beyond the table wrap by dropping high bits.
  assign vpn_ext   = {{PAGE_W{1'b0}}, virt_addr[VADDR_W-1:OFF_W]};
  assign off_ext   = {{OFFSET_W{1'b0}}, virt_addr[OFF_W-1:0]};
  assign tpage_ext = {{PAGE_W{1'b0}}, table_page};

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_page   <= vpn_ext[PAGE_W-1:0];
      cur_offset <= off_ext[OFFSET_W-1:0];
      cur_tpage  <= tpage_ext[PAGE_W-1:0];
      cur_tframe <= table_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      scan_cnt <= '0;
    end else begin
      case (state)
        ST_INIT: begin
          if (!pt_busy) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          scan_cnt <= '0;
          if (accept) begin
            state <= (func == FUNC_WRITE) ? ST_ACK : ST_SCAN;
          end
        end
        ST_SCAN: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == SLOT_W'(LAST)) begin
            state <= ST_RESOLVE;
          end
        end
        ST_RESOLVE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_ACK: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_INIT;
        end
      endcase
    end
  end

  always_comb begin
    pt_ctrl.wr = ack_done;
    pt_ctrl.rd = scan_en && (scan_cnt == '0);
  end

  tlbl_page_table #(
    .PAGE_COUNT(PAGE_COUNT),
    .PAGE_W    (PAGE_W)
  ) u_page_table (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (pt_ctrl),
    .wr_page (cur_tpage),
    .wr_frame(cur_tframe),
    .rd_page (cur_page),
    .rd_frame(pt_frame),
    .busy    (pt_busy)
  );

  // Hit takes the matching entry; a miss fills the first free entry or
  // replaces the oldest, which then counts as arriving with its old rank.
  always_comb begin
    upd.apply = commit;
    upd.fill  = !tok_flags[LAST].hit;
    if (tok_flags[LAST].hit) begin
      upd_slot     = tok_hit_slot[LAST];
      upd_old_rank = tok_hit_rank[LAST];
      upd_frame    = tok_hit_frame[LAST];
    end else if (tok_flags[LAST].free) begin
      upd_slot     = tok_free_slot[LAST];
      upd_old_rank = RANK_W'(BUFFER_ENTRIES);
      upd_frame    = pt_frame;
    end else begin
      upd_slot     = tok_vic_slot[LAST];
      upd_old_rank = tok_vic_rank[LAST];
      upd_frame    = pt_frame;
    end
  end

  for (genvar g = 0; g < BUFFER_ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign cin_flags[g]     = '0;
      assign cin_hit_slot[g]  = '0;
      assign cin_hit_rank[g]  = '0;
      assign cin_hit_frame[g] = '0;
      assign cin_free_slot[g] = '0;
      assign cin_vic_slot[g]  = '0;
      assign cin_vic_rank[g]  = '0;
    end else begin : g_link
      assign cin_flags[g]     = tok_flags[g-1];
      assign cin_hit_slot[g]  = tok_hit_slot[g-1];
      assign cin_hit_rank[g]  = tok_hit_rank[g-1];
      assign cin_hit_frame[g] = tok_hit_frame[g-1];
      assign cin_free_slot[g] = tok_free_slot[g-1];
      assign cin_vic_slot[g]  = tok_vic_slot[g-1];
      assign cin_vic_rank[g]  = tok_vic_rank[g-1];
    end

    tlbl_cell #(
      .PAGE_W(PAGE_W),
      .SLOT_W(SLOT_W),
      .RANK_W(RANK_W),
      .INDEX (g)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .scan_en      (scan_en),
      .page         (cur_page),
      .flags_in     (cin_flags[g]),
      .hit_slot_in  (cin_hit_slot[g]),
      .hit_rank_in  (cin_hit_rank[g]),
      .hit_frame_in (cin_hit_frame[g]),
      .free_slot_in (cin_free_slot[g]),
      .vic_slot_in  (cin_vic_slot[g]),
      .vic_rank_in  (cin_vic_rank[g]),
      .flags_out    (tok_flags[g]),
      .hit_slot_out (tok_hit_slot[g]),
      .hit_rank_out (tok_hit_rank[g]),
      .hit_frame_out(tok_hit_frame[g]),
      .free_slot_out(tok_free_slot[g]),
      .vic_slot_out (tok_vic_slot[g]),
      .vic_rank_out (tok_vic_rank[g]),
      .upd          (upd),
      .upd_slot     (upd_slot),
      .upd_old_rank (upd_old_rank),
      .upd_page     (cur_page),
      .upd_frame    (upd_frame)
    );
  end

  assign slot_ext = {{SLOT_OUT_W{1'b0}}, upd_slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      hits_seen   <= '0;
      misses_seen <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (commit || ack_done) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (commit) begin
        if (tok_flags[LAST].hit) begin
          hits_seen <= hits_seen + 1'b1;
        end else begin
          misses_seen <= misses_seen + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ack_done) begin
      is_write_ack <= 1'b1;
      hit          <= 1'b0;
      frame_number <= '0;
      page_offset  <= '0;
      slot_used    <= '0;
      hit_total    <= '0;
      miss_total   <= '0;
    end else if (commit) begin
      is_write_ack <= 1'b0;
      hit          <= tok_flags[LAST].hit;
      frame_number <= upd_frame;
      page_offset  <= cur_offset;
      slot_used    <= slot_ext[SLOT_OUT_W-1:0];
      hit_total    <= tok_flags[LAST].hit ? hits_seen + 1'b1 : hits_seen;
      miss_total   <= tok_flags[LAST].hit ? misses_seen : misses_seen + 1'b1;
    end
  end

endmodule

### design/tlbl_page_table.sv
// Page table memory with an identity fill sweep after reset.
// Depends on tlbl_pkg for the frame width and the port request struct.
module tlbl_page_table #(
  parameter int PAGE_COUNT = 128,
  parameter int PAGE_W     = 7
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tlbl_pkg::pt_ctrl_t           ctrl,
  input  logic [PAGE_W-1:0]            wr_page,
  input  logic [tlbl_pkg::FRAME_W-1:0] wr_frame,
  input  logic [PAGE_W-1:0]            rd_page,
  output logic [tlbl_pkg::FRAME_W-1:0] rd_frame,
  output logic                         busy
);
  import tlbl_pkg::*;

  logic [FRAME_W-1:0] mem [PAGE_COUNT];
  logic [PAGE_W-1:0]  init_idx;
  logic [PAGE_W+FRAME_W-1:0] init_ext;

  // Entry i starts out holding i, kept to the frame width.
  assign init_ext = {{FRAME_W{1'b0}}, init_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      init_idx <= '0;
    end else if (busy) begin
      init_idx <= init_idx + 1'b1;
      if (init_idx == PAGE_W'(PAGE_COUNT - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[init_idx] <= init_ext[FRAME_W-1:0];
    end else if (ctrl.wr) begin
      mem[wr_page] <= wr_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      rd_frame <= mem[rd_page];
    end
  end

endmodule

### design/tlbl_cell.sv
// One translation buffer entry: page, frame, valid and recency rank.
// Takes the search token from its left neighbor and registers it onward.
// Depends on tlbl_pkg.
module tlbl_cell #(
  parameter int PAGE_W = 7,
  parameter int SLOT_W = 4,
  parameter int RANK_W = 4,
  parameter int INDEX  = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         scan_en,
  input  logic [PAGE_W-1:0]            page,
  input  tlbl_pkg::scan_flags_t        flags_in,
  input  logic [SLOT_W-1:0]            hit_slot_in,
  input  logic [RANK_W-1:0]            hit_rank_in,
  input  logic [tlbl_pkg::FRAME_W-1:0] hit_frame_in,
  input  logic [SLOT_W-1:0]            free_slot_in,
  input  logic [SLOT_W-1:0]            vic_slot_in,
  input  logic [RANK_W-1:0]            vic_rank_in,
  output tlbl_pkg::scan_flags_t        flags_out,
  output logic [SLOT_W-1:0]            hit_slot_out,
  output logic [RANK_W-1:0]            hit_rank_out,
  output logic [tlbl_pkg::FRAME_W-1:0] hit_frame_out,
  output logic [SLOT_W-1:0]            free_slot_out,
  output logic [SLOT_W-1:0]            vic_slot_out,
  output logic [RANK_W-1:0]            vic_rank_out,
  input  tlbl_pkg::upd_cmd_t           upd,
  input  logic [SLOT_W-1:0]            upd_slot,
  input  logic [RANK_W-1:0]            upd_old_rank,
  input  logic [PAGE_W-1:0]            upd_page,
  input  logic [tlbl_pkg::FRAME_W-1:0] upd_frame
);
  import tlbl_pkg::*;

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);

  logic               valid;
  logic [RANK_W-1:0]  rank;
  logic [PAGE_W-1:0]  entry_page;
  logic [FRAME_W-1:0] entry_frame;
  logic               match;

  scan_flags_t        flags_next;
  logic [SLOT_W-1:0]  hit_slot_next;
  logic [RANK_W-1:0]  hit_rank_next;
  logic [FRAME_W-1:0] hit_frame_next;
  logic [SLOT_W-1:0]  free_slot_next;
  logic [SLOT_W-1:0]  vic_slot_next;
  logic [RANK_W-1:0]  vic_rank_next;

  assign match = valid && (entry_page == page);

  // The first matching entry, the first free entry and the oldest entry
  // (lowest index on a tie) win as the token passes along the row.
  always_comb begin
    flags_next     = flags_in;
    hit_slot_next  = hit_slot_in;
    hit_rank_next  = hit_rank_in;
    hit_frame_next = hit_frame_in;
    free_slot_next = free_slot_in;
    vic_slot_next  = vic_slot_in;
    vic_rank_next  = vic_rank_in;
    if (!flags_in.hit && match) begin
      flags_next.hit = 1'b1;
      hit_slot_next  = MY_SLOT;
      hit_rank_next  = rank;
      hit_frame_next = entry_frame;
    end
    if (!flags_in.free && !valid) begin
      flags_next.free = 1'b1;
      free_slot_next  = MY_SLOT;
    end
    if (!flags_in.vic || (rank > vic_rank_in)) begin
      flags_next.vic = 1'b1;
      vic_slot_next  = MY_SLOT;
      vic_rank_next  = rank;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_en) begin
      flags_out     <= flags_next;
      hit_slot_out  <= hit_slot_next;
      hit_rank_out  <= hit_rank_next;
      hit_frame_out <= hit_frame_next;
      free_slot_out <= free_slot_next;
      vic_slot_out  <= vic_slot_next;
      vic_rank_out  <= vic_rank_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (upd.apply) begin
      if (upd_slot == MY_SLOT) begin
        rank <= '0;
        if (upd.fill) begin
          valid <= 1'b1;
        end
      end else if (valid && (rank < upd_old_rank)) begin
        rank <= rank + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.apply && upd.fill && (upd_slot == MY_SLOT)) begin
      entry_page  <= upd_page;
      entry_frame <= upd_frame;
    end
  end

endmodule

### design/tlbl_checker.sv
// Port-level checks of the translation unit, bound to its top level.
// Depends on tlb_lru_translate_unit_assert.svh for the assertion macros.
`include "tlb_lru_translate_unit_assert.svh"

module tlbl_checker #(
  parameter int ENTRIES = 10
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_stall,
  input logic                            rsp_valid,
  input logic                            rsp_stall,
  input logic                            is_write_ack,
  input logic                            hit,
  input logic [tlbl_pkg::FRAME_W-1:0]    frame_number,
  input logic [tlbl_pkg::OFFSET_W-1:0]   page_offset,
  input logic [tlbl_pkg::SLOT_OUT_W-1:0] slot_used,
  input logic [tlbl_pkg::TOTAL_W-1:0]    hit_total,
  input logic [tlbl_pkg::TOTAL_W-1:0]    miss_total
);

  // A write acknowledge carries nothing but its flag.
  `TLBL_ASSERT_NOW(a_ack_zero, clk, rst, rsp_valid && is_write_ack, !hit && (frame_number == '0) && (page_offset == '0) && (slot_used == '0) && (hit_total == '0) && (miss_total == '0), "write acknowledge with nonzero fields")

  // The block works on one item at a time, so it stalls right after a take.
  `TLBL_ASSERT_NEXT(a_one_at_a_time, clk, rst, req_valid && !req_stall, req_stall, "request taken while an item is in progress")

  // A translation names an entry that exists; checked only for buffers of at most 16 entries.
  `TLBL_ASSERT_NOW(a_slot_range, clk, rst, rsp_valid && !is_write_ack, (ENTRIES > 16) || (32'(slot_used) < ENTRIES), "slot outside the buffer")

  // A stalled response holds its item.
  `TLBL_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(hit_total) && $stable(miss_total) && $stable(slot_used) && $stable(frame_number), "stalled response changed")

endmodule

bind tlb_lru_translate_unit tlbl_checker #(.ENTRIES(BUFFER_ENTRIES)) u_checker (.*);
